/* rtl/core/hprm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hprm_pkg: shared constants for the hall pulse rpm meter
// Field widths, register map, reset values and fixed-point constants.
// ----------------------------------------------------------------------------
package hprm_pkg;

  // Defaults for the top-level parameters
  localparam int RING_DEPTH_DEF = 10;
  localparam int CHANNELS_DEF   = 2;

  // Field widths
  localparam int TIME_W  = 32;
  localparam int RPM_W   = 24;
  localparam int CFG_W   = 16;
  localparam int ALPHA_W = 9;
  localparam int FRAC_W  = 8;

  // APB port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int REG_W   = 2;

  localparam logic [REG_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [REG_W-1:0] REG_TIMEOUT  = 2'd1;
  localparam logic [REG_W-1:0] REG_ALPHA    = 2'd2;

  localparam logic [CFG_W-1:0]   DEBOUNCE_RST = 16'd5;
  localparam logic [CFG_W-1:0]   TIMEOUT_RST  = 16'd2000;
  localparam logic [ALPHA_W-1:0] ALPHA_RST    = 9'd77;

  // 60000 rpm-ms times 256 (Q8), and the largest rpm that can come out
  localparam logic [RPM_W-1:0]   RPM_NUMER = 24'd15360000;
  localparam logic [RPM_W-1:0]   RPM_MAX   = 24'd15360000;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;
  localparam int                 ROUND_HALF = 128;

endpackage : hprm_pkg
`default_nettype wire

/* rtl/core/hprm_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hprm_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hprm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 20,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : hprm_ram
`default_nettype wire

/* rtl/core/hall_pulse_rpm_meter_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hall_pulse_rpm_meter_top: two-channel period-averaging tachometer
// Collects pulse intervals per channel and reports smoothed rpm in Q8.
// ----------------------------------------------------------------------------
// On a pulse beat (command 0), the interval since the channel's
// last accepted pulse is written into that channel's ring of RING_DEPTH
// entries when it is above debounce_ms, and the block is ready again on the
// next cycle. A query beat (command 1) returns exactly one result beat. A
// query on a channel that timed out, that has no stored interval, or that is
// out of range answers zero. Any other query runs through
// the ring one entry per cycle (one RAM read port), then through a bit-serial
// restoring divider that yields one quotient bit per cycle (24 plus the width
// of the entry count, 28 bits at the default depth), then through a
// shift-add EMA over the 9 bits of alpha. One item is worked on at a time;
// the finished result sits in an output register, so the next item is taken
// while the result waits on a stalled receiver. The ring needs no clearing
// pass after reset: a fill count per channel marks which entries hold data.
// Registers lie at byte addresses 0 (debounce_ms), 4 (timeout_ms) and 8
// (alpha_q8); alpha above 256 acts as 256.
// ----------------------------------------------------------------------------
module hall_pulse_rpm_meter_top #(
  parameter int RING_DEPTH = hprm_pkg::RING_DEPTH_DEF,
  parameter int CHANNELS   = hprm_pkg::CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hprm_pkg::PADDR_W-1:0] paddr,
  input  logic [hprm_pkg::PDATA_W-1:0] pwdata,
  output logic [hprm_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  // item channel
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic                         command,
  input  logic                         channel,
  input  logic [hprm_pkg::TIME_W-1:0]  time_ms,
  // result channel
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic                         channel_out,
  output logic [hprm_pkg::RPM_W-1:0]   rpm_q8
);

  import hprm_pkg::*;

  localparam int CNT_W     = $clog2(RING_DEPTH + 1);
  localparam int POS_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RAM_DEPTH = CHANNELS * RING_DEPTH;
  localparam int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
  localparam int SUM_W     = TIME_W + CNT_W;   // sum of up to RING_DEPTH intervals
  localparam int NUM_W     = RPM_W + CNT_W;    // 15360000 * count
  localparam int STEP_W    = $clog2(NUM_W + 1);
  localparam int ACC_W     = RPM_W + ALPHA_W;  // a*raw + (256-a)*prev + 128

  // One-hot sequencer: idle, ring sweep, divide, filter, result handoff
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_EMA  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state;

  // Configuration registers
  logic [CFG_W-1:0]   debounce_ms;
  logic [CFG_W-1:0]   timeout_ms;
  logic [ALPHA_W-1:0] alpha_q8;

  // Per-channel state
  logic [TIME_W-1:0] last_time [CHANNELS];
  logic [POS_W-1:0]  wpos      [CHANNELS];
  logic [CNT_W-1:0]  fill      [CHANNELS];
  logic [RPM_W-1:0]  filt      [CHANNELS];

  // Query working registers
  logic [CH_W-1:0]    q_ch;
  logic               q_chan;
  logic [CNT_W-1:0]   q_cnt;
  logic [CNT_W-1:0]   rd_idx;
  logic               rd_pend;
  logic [CNT_W-1:0]   recv;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   rem;
  logic [NUM_W-1:0]   num_q;
  logic [STEP_W-1:0]  step;
  logic [ALPHA_W-1:0] ma;
  logic [ALPHA_W-1:0] mb;
  logic [ACC_W-1:0]   raw_sh;
  logic [ACC_W-1:0]   prev_sh;
  logic [ACC_W-1:0]   acc;
  logic [RPM_W-1:0]   res;

  // RAM ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [TIME_W-1:0] ram_rdata;

  // Item decode
  logic              accept;
  logic              ch_ok;
  logic [CH_W-1:0]   ch_idx;
  logic [TIME_W-1:0] gap;
  logic              pulse_take;

  // Datapath helpers
  logic [SUM_W-1:0]   sum_next;
  logic [SUM_W:0]     trial;
  logic               fits;
  logic [NUM_W-1:0]   num_q_next;
  logic [ALPHA_W-1:0] a_sat;
  logic [ACC_W-1:0]   acc_next;
  logic [RPM_W-1:0]   ema_val;

  // --------------------------------------------------------------------------
  // Handshakes and decode
  // --------------------------------------------------------------------------
  assign pready     = 1'b1;
  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;

  assign ch_idx = CH_W'(channel);
  assign ch_ok  = (int'(channel) < CHANNELS);
  // Wraps modulo 2^32, as the timestamp does
  assign gap    = time_ms - last_time[ch_idx];

  assign pulse_take = accept && !command && ch_ok && (gap > TIME_W'(debounce_ms));

  // Pulse writes land at the channel's write position
  assign ram_we    = pulse_take;
  assign ram_waddr = ADDR_W'(ch_idx) * ADDR_W'(RING_DEPTH) + ADDR_W'(wpos[ch_idx]);

  // Sweep reads the first q_cnt entries of the queried ring
  assign ram_re    = (state == ST_SUM) && (rd_idx < q_cnt);
  assign ram_raddr = ADDR_W'(q_ch) * ADDR_W'(RING_DEPTH) + ADDR_W'(rd_idx);

  hprm_ram #(
    .WIDTH (TIME_W),
    .DEPTH (RAM_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (gap),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Datapath: accumulate, one restoring-division bit, one shift-add EMA step
  // --------------------------------------------------------------------------
  assign sum_next = sum + SUM_W'(ram_rdata);

  // Shift the next numerator bit into the partial remainder and try the divisor
  assign trial      = {rem, num_q[NUM_W-1]};
  assign fits       = (trial >= {1'b0, sum});
  assign num_q_next = {num_q[NUM_W-2:0], fits};

  // Alpha saturates at one (256 in Q8)
  assign a_sat = (alpha_q8 > ALPHA_ONE) ? ALPHA_ONE : alpha_q8;

  assign acc_next = acc + (ma[0] ? raw_sh : '0) + (mb[0] ? prev_sh : '0);
  assign ema_val  = acc_next[FRAC_W +: RPM_W];

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RST;
      timeout_ms  <= TIMEOUT_RST;
      alpha_q8    <= ALPHA_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[PADDR_W-1:2])
        REG_DEBOUNCE: debounce_ms <= pwdata[CFG_W-1:0];
        REG_TIMEOUT:  timeout_ms  <= pwdata[CFG_W-1:0];
        REG_ALPHA:    alpha_q8    <= pwdata[ALPHA_W-1:0];
        default: ;  // writes beyond the map are dropped
      endcase
    end
  end

  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_DEBOUNCE: prdata = PDATA_W'(debounce_ms);
      REG_TIMEOUT:  prdata = PDATA_W'(timeout_ms);
      REG_ALPHA:    prdata = PDATA_W'(alpha_q8);
      default:      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Per-channel pulse state: last time, write position, fill count
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_time[i] <= '0;
        wpos[i]      <= '0;
        fill[i]      <= '0;
      end
    end else if (pulse_take) begin
      last_time[ch_idx] <= time_ms;
      // Advance the write position around the ring
      if (wpos[ch_idx] == POS_W'(RING_DEPTH - 1)) begin
        wpos[ch_idx] <= '0;
      end else begin
        wpos[ch_idx] <= wpos[ch_idx] + POS_W'(1);
      end
      // Count valid entries until the ring is full
      if (fill[ch_idx] != CNT_W'(RING_DEPTH)) begin
        fill[ch_idx] <= fill[ch_idx] + CNT_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Query sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_pend <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        filt[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && command) begin
            q_chan <= channel;
            q_ch   <= ch_idx;
            // Out-of-range channel, stale sensor or empty ring: answer zero
            if (!ch_ok || gap > TIME_W'(timeout_ms) || fill[ch_idx] == '0) begin
              res   <= '0;
              state <= ST_DONE;
            end else begin
              q_cnt   <= fill[ch_idx];
              rd_idx  <= '0;
              rd_pend <= 1'b0;
              recv    <= '0;
              sum     <= '0;
              state   <= ST_SUM;
            end
          end
        end

        ST_SUM: begin
          if (ram_re) begin
            rd_idx <= rd_idx + CNT_W'(1);
          end
          rd_pend <= ram_re;
          if (rd_pend) begin
            sum  <= sum_next;
            recv <= recv + CNT_W'(1);
            if (recv == q_cnt - CNT_W'(1)) begin
              // Last entry in: load the numerator and start dividing
              rem   <= '0;
              num_q <= NUM_W'(q_cnt) * NUM_W'(RPM_NUMER);
              step  <= '0;
              state <= ST_DIV;
            end
          end
        end

        ST_DIV: begin
          rem   <= fits ? SUM_W'(trial - {1'b0, sum}) : trial[SUM_W-1:0];
          num_q <= num_q_next;
          step  <= step + STEP_W'(1);
          if (step == STEP_W'(NUM_W - 1)) begin
            // Quotient done; set up the filter multiply
            raw_sh  <= ACC_W'(num_q_next[RPM_W-1:0]);
            prev_sh <= ACC_W'(filt[q_ch]);
            ma      <= a_sat;
            mb      <= ALPHA_ONE - a_sat;
            acc     <= ACC_W'(ROUND_HALF);
            step    <= '0;
            state   <= ST_EMA;
          end
        end

        ST_EMA: begin
          acc     <= acc_next;
          ma      <= ma >> 1;
          mb      <= mb >> 1;
          raw_sh  <= raw_sh << 1;
          prev_sh <= prev_sh << 1;
          step    <= step + STEP_W'(1);
          if (step == STEP_W'(ALPHA_W - 1)) begin
            filt[q_ch] <= ema_val;
            res        <= ema_val;
            state      <= ST_DONE;
          end
        end

        ST_DONE: begin
          // Hold until the output register is free
          if (!result_valid || !result_stall) begin
            state <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (state == ST_DONE && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!result_valid || !result_stall)) begin
      channel_out <= q_chan;
      rpm_q8      <= res;
    end
  end

endmodule : hall_pulse_rpm_meter_top
`default_nettype wire

/* rtl/core/hprm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hprm_checker: port-level assertions for the rpm meter
// Watches the item and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module hprm_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       item_valid,
  input wire logic                       item_stall,
  input wire logic                       command,
  input wire logic                       result_valid,
  input wire logic                       result_stall,
  input wire logic                       channel_out,
  input wire logic [hprm_pkg::RPM_W-1:0] rpm_q8
);

  import hprm_pkg::*;

  // A stalled result beat stays
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat dropped while stalled");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(rpm_q8) && $stable(channel_out))
    else $error("result payload changed while stalled");

  // Rpm never exceeds the one-millisecond-period ceiling
  a_rpm_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> rpm_q8 <= RPM_MAX)
    else $error("rpm above ceiling");

  // A pulse finishes in its own cycle
  a_pulse_fast: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && !command |=> !item_stall)
    else $error("stall after pulse beat");

  // A query occupies the block until its result is handed off
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && command |=> item_stall)
    else $error("no stall after query beat");

endmodule : hprm_checker

bind hall_pulse_rpm_meter_top hprm_checker u_hprm_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .command      (command),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .channel_out  (channel_out),
  .rpm_q8       (rpm_q8)
);
`default_nettype wire
